/* rtl/core/bmm_pkg.sv */
package bmm_pkg;

   // Request actions
   typedef enum logic [1:0] {
      ACT_WRITE_A = 2'd0,
      ACT_WRITE_B = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_READ_C  = 2'd3
   } action_type;

   // Sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'd0,
      SEQ_RUN   = 2'd1,
      SEQ_DRAIN = 2'd2
   } seq_state_type;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_ROWS_A        = 3'd0;
   localparam logic [2:0] REG_INNER_LEN     = 3'd1;
   localparam logic [2:0] REG_COLS_B        = 3'd2;
   localparam logic [2:0] REG_BATCH_P_COUNT = 3'd3;
   localparam logic [2:0] REG_BATCH_Q_COUNT = 3'd4;

   // Register reset values
   localparam logic [3:0] ROWS_A_RESET        = 4'd8;
   localparam logic [3:0] INNER_LEN_RESET     = 4'd8;
   localparam logic [3:0] COLS_B_RESET        = 4'd8;
   localparam logic [2:0] BATCH_P_COUNT_RESET = 3'd4;
   localparam logic [2:0] BATCH_Q_COUNT_RESET = 3'd4;

   // Status codes
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      action_type         action;
      logic [2:0]         row;
      logic [2:0]         col;
      logic [1:0]         batch_p;
      logic [1:0]         batch_q;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               status;
   } rsp_type;

   // Control that travels with each product through the MAC pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

/* rtl/core/bmm_mac.sv */
module bmm_mac #(
   parameter int ADDR_W = 10,
   parameter int ACC_W  = 68
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bmm_pkg::mac_ctl_type      issue,
   input  logic [ADDR_W-1:0]         c_addr,
   input  logic signed [31:0]        a_data,
   input  logic signed [31:0]        b_data,
   output logic                      c_wr_en,
   output logic [ADDR_W-1:0]         c_wr_addr,
   output logic [31:0]               c_wr_data,
   output logic                      busy
);

   bmm_pkg::mac_ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [ADDR_W-1:0]         s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   shifted;
   logic                      fits;

   // Advance control through the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= issue;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   // Multiply operands as they leave the memories, then accumulate
   assign prod_in = a_data * b_data;
   assign acc_in  = s2_ctl_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      s1_addr_ff <= c_addr;
      s2_addr_ff <= s1_addr_ff;
      s3_addr_ff <= s2_addr_ff;
      prod_ff    <= prod_in;
      if (s2_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // Scale the finished sum and saturate it to a word
   assign shifted = acc_ff >>> 16;
   assign fits    = (&shifted[ACC_W-1:31]) || !(|shifted[ACC_W-1:31]);

   always_comb begin
      if (fits) begin
         c_wr_data = shifted[31:0];
      end else if (shifted[ACC_W-1]) begin
         c_wr_data = 32'h8000_0000;
      end else begin
         c_wr_data = 32'h7fff_ffff;
      end
   end

   assign c_wr_en   = s3_ctl_ff.valid && s3_ctl_ff.last;
   assign c_wr_addr = s3_addr_ff;
   assign busy      = s1_ctl_ff.valid || s2_ctl_ff.valid || s3_ctl_ff.valid;

endmodule

/* rtl/core/bmm_seq.sv */
module bmm_seq #(
   parameter int DIM_W = 3,
   parameter int BAT_W = 2,
   localparam int ADDR_W = 2 * BAT_W + 2 * DIM_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIM_W-1:0]     m_last,
   input  logic [DIM_W-1:0]     k_last,
   input  logic [DIM_W-1:0]     n_last,
   input  logic [BAT_W-1:0]     p_last,
   input  logic [BAT_W-1:0]     q_last,
   input  logic                 mac_busy,
   output bmm_pkg::mac_ctl_type issue,
   output logic [ADDR_W-1:0]    a_addr,
   output logic [ADDR_W-1:0]    b_addr,
   output logic [ADDR_W-1:0]    c_addr,
   output logic                 idle,
   output logic                 done
);

   bmm_pkg::seq_state_type state_ff, state_in;
   logic [BAT_W-1:0] p_ff, p_in, q_ff, q_in;
   logic [DIM_W-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic             t_end, j_end, i_end, q_end, p_end, all_end;

   assign t_end   = (t_ff == k_last);
   assign j_end   = (j_ff == n_last);
   assign i_end   = (i_ff == m_last);
   assign q_end   = (q_ff == q_last);
   assign p_end   = (p_ff == p_last);
   assign all_end = t_end && j_end && i_end && q_end && p_end;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmm_pkg::SEQ_IDLE: begin
            if (start) state_in = bmm_pkg::SEQ_RUN;
         end
         bmm_pkg::SEQ_RUN: begin
            if (all_end) state_in = bmm_pkg::SEQ_DRAIN;
         end
         bmm_pkg::SEQ_DRAIN: begin
            if (!mac_busy) state_in = bmm_pkg::SEQ_IDLE;
         end
         default: state_in = bmm_pkg::SEQ_IDLE;
      endcase
   end

   // Step the loop indexes, inner sum index fastest
   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      i_in = i_ff;
      j_in = j_ff;
      t_in = t_ff;
      if (start) begin
         p_in = '0;
         q_in = '0;
         i_in = '0;
         j_in = '0;
         t_in = '0;
      end else if (state_ff == bmm_pkg::SEQ_RUN) begin
         t_in = t_end ? '0 : t_ff + 1'b1;
         if (t_end) begin
            j_in = j_end ? '0 : j_ff + 1'b1;
            if (j_end) begin
               i_in = i_end ? '0 : i_ff + 1'b1;
               if (i_end) begin
                  q_in = q_end ? '0 : q_ff + 1'b1;
                  if (q_end) begin
                     p_in = p_end ? '0 : p_ff + 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmm_pkg::SEQ_IDLE;
         p_ff     <= '0;
         q_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         q_ff     <= q_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
      end
   end

   // Outputs
   always_comb begin
      issue.valid = (state_ff == bmm_pkg::SEQ_RUN);
      issue.first = (t_ff == '0);
      issue.last  = t_end;
      a_addr      = {p_ff, q_ff, i_ff, t_ff};
      b_addr      = {p_ff, q_ff, t_ff, j_ff};
      c_addr      = {p_ff, q_ff, i_ff, j_ff};
      idle        = (state_ff == bmm_pkg::SEQ_IDLE);
      done        = (state_ff == bmm_pkg::SEQ_DRAIN) && !mac_busy;
   end

endmodule

/* rtl/core/batched_matrix_multiply.sv */
// Batched matrix multiply: C(:,:,p,q) = A(:,:,p,q) * B(:,:,p,q) in signed Q16.16.
// Requests arrive on req_valid/req_ready with a req_type payload; each request
// gives exactly one response on rsp_valid/rsp_ready (rsp_type payload).
// Write A, write B and read C requests are accepted one per cycle while rsp_ready
// is high and answered in the cycle after acceptance; an index outside the
// configured sizes changes nothing and answers with status 1. A compute request
// holds req_ready low while one shared 32x32 multiplier and accumulator walks
// every batch, row, column and inner index, one product per cycle; each product
// passes through memory read, multiply, accumulate and write back before the
// response appears. Sizes are set through the csr_ APB port (rows_a, inner_len,
// cols_b, batch_p_count, batch_q_count at byte addresses 0..16); a size of 0
// acts as 1 and one above the bound acts as the bound.
// Reset restores the register defaults and empties the response register; the
// operand and result memories keep undefined contents until written.
// A response waits in its output register while rsp_ready is low; a new
// request is then taken only in the cycle in which that response leaves.
module batched_matrix_multiply #(
   parameter int MAX_DIM       = 8,
   parameter int MAX_BATCH_DIM = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bmm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmm_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int BAT_W       = (MAX_BATCH_DIM > 1) ? $clog2(MAX_BATCH_DIM) : 1;
   localparam int SIZE_W      = $clog2(MAX_DIM + 1);
   localparam int BSIZE_W     = $clog2(MAX_BATCH_DIM + 1);
   localparam int ADDR_W      = 2 * BAT_W + 2 * DIM_W;
   localparam int STORE_DEPTH = 2 ** ADDR_W;
   localparam int ACC_W       = 64 + SIZE_W;

   // Configuration registers
   logic [3:0] rows_a_ff, rows_a_in;
   logic [3:0] inner_len_ff, inner_len_in;
   logic [3:0] cols_b_ff, cols_b_in;
   logic [2:0] batch_p_count_ff, batch_p_count_in;
   logic [2:0] batch_q_count_ff, batch_q_count_in;
   logic       csr_write;

   // Effective sizes
   logic [SIZE_W-1:0]  m_eff, k_eff, n_eff;
   logic [BSIZE_W-1:0] p_eff, q_eff;

   // Request decode
   logic              req_accept;
   logic              in_range;
   logic              batch_ok;
   logic [31:0]       row_lim, col_lim;
   logic [ADDR_W-1:0] req_addr;
   logic              wr_a, wr_b, rd_c, start;

   // Memories and read registers
   logic [31:0]        a_store_ff [STORE_DEPTH];
   logic [31:0]        b_store_ff [STORE_DEPTH];
   logic [31:0]        c_store_ff [STORE_DEPTH];
   logic signed [31:0] a_rd_ff, b_rd_ff;
   logic [31:0]        c_rd_ff;

   // Response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff, rsp_status_in;
   logic rsp_is_read_ff, rsp_is_read_in;

   // Sequencer and MAC links
   bmm_pkg::mac_ctl_type issue;
   logic [ADDR_W-1:0]    seq_a_addr, seq_b_addr, seq_c_addr;
   logic                 seq_idle, seq_done, mac_busy;
   logic                 c_wr_en;
   logic [ADDR_W-1:0]    c_wr_addr;
   logic [31:0]          c_wr_data;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rows_a_in        = rows_a_ff;
      inner_len_in     = inner_len_ff;
      cols_b_in        = cols_b_ff;
      batch_p_count_in = batch_p_count_ff;
      batch_q_count_in = batch_q_count_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            bmm_pkg::REG_ROWS_A:        rows_a_in        = csr_pwdata[3:0];
            bmm_pkg::REG_INNER_LEN:     inner_len_in     = csr_pwdata[3:0];
            bmm_pkg::REG_COLS_B:        cols_b_in        = csr_pwdata[3:0];
            bmm_pkg::REG_BATCH_P_COUNT: batch_p_count_in = csr_pwdata[2:0];
            bmm_pkg::REG_BATCH_Q_COUNT: batch_q_count_in = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         bmm_pkg::REG_ROWS_A:        csr_prdata = 32'(rows_a_ff);
         bmm_pkg::REG_INNER_LEN:     csr_prdata = 32'(inner_len_ff);
         bmm_pkg::REG_COLS_B:        csr_prdata = 32'(cols_b_ff);
         bmm_pkg::REG_BATCH_P_COUNT: csr_prdata = 32'(batch_p_count_ff);
         bmm_pkg::REG_BATCH_Q_COUNT: csr_prdata = 32'(batch_q_count_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff        <= bmm_pkg::ROWS_A_RESET;
         inner_len_ff     <= bmm_pkg::INNER_LEN_RESET;
         cols_b_ff        <= bmm_pkg::COLS_B_RESET;
         batch_p_count_ff <= bmm_pkg::BATCH_P_COUNT_RESET;
         batch_q_count_ff <= bmm_pkg::BATCH_Q_COUNT_RESET;
      end else begin
         rows_a_ff        <= rows_a_in;
         inner_len_ff     <= inner_len_in;
         cols_b_ff        <= cols_b_in;
         batch_p_count_ff <= batch_p_count_in;
         batch_q_count_ff <= batch_q_count_in;
      end
   end

   // Clamp each size into one up to its bound
   always_comb begin
      m_eff = (rows_a_ff == '0) ? SIZE_W'(1) :
              (32'(rows_a_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : SIZE_W'(rows_a_ff);
      k_eff = (inner_len_ff == '0) ? SIZE_W'(1) :
              (32'(inner_len_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : SIZE_W'(inner_len_ff);
      n_eff = (cols_b_ff == '0) ? SIZE_W'(1) :
              (32'(cols_b_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : SIZE_W'(cols_b_ff);
      p_eff = (batch_p_count_ff == '0) ? BSIZE_W'(1) :
              (32'(batch_p_count_ff) > MAX_BATCH_DIM) ? BSIZE_W'(MAX_BATCH_DIM) :
              BSIZE_W'(batch_p_count_ff);
      q_eff = (batch_q_count_ff == '0) ? BSIZE_W'(1) :
              (32'(batch_q_count_ff) > MAX_BATCH_DIM) ? BSIZE_W'(MAX_BATCH_DIM) :
              BSIZE_W'(batch_q_count_ff);
   end

   // Decode the request and check its indexes
   assign req_ready  = seq_idle && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      row_lim = (req_data.action == bmm_pkg::ACT_WRITE_B) ? 32'(k_eff) : 32'(m_eff);
      col_lim = (req_data.action == bmm_pkg::ACT_WRITE_A) ? 32'(k_eff) : 32'(n_eff);
      batch_ok = (32'(req_data.batch_p) < 32'(p_eff)) &&
                 (32'(req_data.batch_q) < 32'(q_eff));
      in_range = batch_ok && (32'(req_data.row) < row_lim) &&
                 (32'(req_data.col) < col_lim);
      req_addr = {BAT_W'(req_data.batch_p), BAT_W'(req_data.batch_q),
                  DIM_W'(req_data.row), DIM_W'(req_data.col)};
      wr_a  = req_accept && in_range && (req_data.action == bmm_pkg::ACT_WRITE_A);
      wr_b  = req_accept && in_range && (req_data.action == bmm_pkg::ACT_WRITE_B);
      rd_c  = req_accept && in_range && (req_data.action == bmm_pkg::ACT_READ_C);
      start = req_accept && (req_data.action == bmm_pkg::ACT_COMPUTE);
   end

   // Operand memories: written by requests, read by the sequencer
   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_store_ff[req_addr] <= req_data.value;
      end
      a_rd_ff <= a_store_ff[seq_a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         b_store_ff[req_addr] <= req_data.value;
      end
      b_rd_ff <= b_store_ff[seq_b_addr];
   end

   // Result memory: written by the MAC, read by requests
   always_ff @(posedge clock) begin
      if (c_wr_en) begin
         c_store_ff[c_wr_addr] <= c_wr_data;
      end
      if (rd_c) begin
         c_rd_ff <= c_store_ff[req_addr];
      end
   end

   // Load, hold or drop the response
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_is_read_in = rsp_is_read_ff;
      priority if (req_accept && !start) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = in_range ? bmm_pkg::STATUS_DONE : bmm_pkg::STATUS_RANGE;
         rsp_is_read_in = rd_c;
      end else if (seq_done) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = bmm_pkg::STATUS_DONE;
         rsp_is_read_in = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_is_read_ff <= rsp_is_read_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.status     = rsp_status_ff;
   assign rsp_data.read_value = rsp_is_read_ff ? c_rd_ff : '0;

   bmm_seq #(
      .DIM_W (DIM_W),
      .BAT_W (BAT_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .m_last   (DIM_W'(m_eff - SIZE_W'(1))),
      .k_last   (DIM_W'(k_eff - SIZE_W'(1))),
      .n_last   (DIM_W'(n_eff - SIZE_W'(1))),
      .p_last   (BAT_W'(p_eff - BSIZE_W'(1))),
      .q_last   (BAT_W'(q_eff - BSIZE_W'(1))),
      .mac_busy (mac_busy),
      .issue    (issue),
      .a_addr   (seq_a_addr),
      .b_addr   (seq_b_addr),
      .c_addr   (seq_c_addr),
      .idle     (seq_idle),
      .done     (seq_done)
   );

   bmm_mac #(
      .ADDR_W (ADDR_W),
      .ACC_W  (ACC_W)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .c_addr    (seq_c_addr),
      .a_data    (a_rd_ff),
      .b_data    (b_rd_ff),
      .c_wr_en   (c_wr_en),
      .c_wr_addr (c_wr_addr),
      .c_wr_data (c_wr_data),
      .busy      (mac_busy)
   );

`ifndef NO_ASSERTIONS
   // No request is taken while a compute runs
   assert property (@(posedge clock) disable iff (reset) !seq_idle |-> !req_ready)
      else $error("request accepted during compute");

   // Results are written back only while a compute is in flight
   assert property (@(posedge clock) disable iff (reset) c_wr_en |-> !seq_idle)
      else $error("result write outside compute");

   // End of compute loads a good response
   assert property (@(posedge clock) disable iff (reset)
      seq_done |=> rsp_valid_ff && (rsp_status_ff == bmm_pkg::STATUS_DONE) && !rsp_is_read_ff)
      else $error("compute finished without response");

   // The sequencer only finishes after the MAC pipeline is empty
   assert property (@(posedge clock) disable iff (reset) seq_done |-> !c_wr_en && !mac_busy)
      else $error("compute finished with products in flight");
`endif

endmodule
